@@ src/bie_pkg.sv @@
// Shared constants, types and sequencer states for the bar indicator engine.
`timescale 1ns / 1ps
package bie_pkg;

  localparam int VOLUME_WINDOW = 25;
  localparam int CLOSE_WINDOW  = 50;
  localparam int HIGH_WINDOW   = 20;
  localparam int RANGE_WINDOW  = 14;

  localparam int PRICE_W = 32;
  localparam int VOL_W   = 48;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;

  localparam int CSUM_W = PRICE_W + $clog2(CLOSE_WINDOW);
  localparam int VSUM_W = VOL_W + $clog2(VOLUME_WINDOW);
  localparam int RSUM_W = PRICE_W + $clog2(RANGE_WINDOW);

  localparam int MAX_A  = (VSUM_W > CSUM_W) ? VSUM_W : CSUM_W;
  localparam int MAX_B  = (MAX_A > RSUM_W) ? MAX_A : RSUM_W;
  localparam int MAX_C  = (MAX_B > PRICE_W + 16) ? MAX_B : PRICE_W + 16;
  localparam int DIV_W  = MAX_C + 1;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam int CLOSE_AW = $clog2(CLOSE_WINDOW);
  localparam int HCNT_W   = $clog2(HIGH_WINDOW + 1);

  localparam int ONE_Q16 = 65536;
  localparam int ROC_MAX = 32'h7FFF_FFFF;

  typedef logic [PRICE_W-1:0]  price_t;
  typedef logic [VOL_W-1:0]    vol_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [CSUM_W-1:0]   csum_t;
  typedef logic [VSUM_W-1:0]   vsum_t;
  typedef logic [RSUM_W-1:0]   rsum_t;
  typedef logic [DIV_W-1:0]    div_t;
  typedef logic [DCNT_W-1:0]   dcnt_t;
  typedef logic [CLOSE_AW-1:0] caddr_t;
  typedef logic [HCNT_W-1:0]   hcnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_OLD,
    S_TR,
    S_PUSH,
    S_GO,
    S_WAIT,
    S_DONE
  } state_t;

  // handshake between sequencer and the serial units
  typedef struct packed {
    logic start;
    logic push;
  } unit_ctl_t;

endpackage

@@ src/bie_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/bie_sdiv.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bie_sdiv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  bie_pkg::div_t         dividend,
  input  bie_pkg::price_t       divisor,
  output logic                  busy,
  output bie_pkg::div_t         quotient
);

  logic [bie_pkg::PRICE_W:0] rem_r, rem_nxt;
  bie_pkg::div_t             qd_r, qd_nxt;
  bie_pkg::dcnt_t            cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [bie_pkg::PRICE_W:0] trial;
  logic                      ge;

  always_comb begin
    trial   = {rem_r[bie_pkg::PRICE_W-1:0], qd_r[bie_pkg::DIV_W-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = rem_r;
    qd_nxt  = qd_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      qd_nxt   = dividend;
      cnt_nxt  = bie_pkg::dcnt_t'(bie_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, divisor}) : trial;
      qd_nxt  = {qd_r[bie_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == bie_pkg::dcnt_t'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
  end

  assign busy     = busy_r;
  assign quotient = qd_r;

endmodule

@@ src/bie_hwin.sv @@
// High-price window: shift line that rotates once per bar to find its maximum.
`timescale 1ns / 1ps
module bie_hwin (
  input  logic               clk,
  input  logic               rst_n,
  input  bie_pkg::unit_ctl_t ctl,
  input  bie_pkg::price_t    push_val,
  output logic               busy,
  output bie_pkg::price_t    max_val
);

  bie_pkg::price_t line_r [bie_pkg::HIGH_WINDOW];
  bie_pkg::price_t max_r, max_nxt;
  bie_pkg::hcnt_t  cnt_r, cnt_nxt;

  always_comb begin
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    if (ctl.start) begin
      max_nxt = '0;
      cnt_nxt = bie_pkg::hcnt_t'(bie_pkg::HIGH_WINDOW);
    end else if (cnt_r != '0) begin
      if (line_r[bie_pkg::HIGH_WINDOW-1] > max_r) begin
        max_nxt = line_r[bie_pkg::HIGH_WINDOW-1];
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    max_r <= max_nxt;
    // push shifts in a new high; a scan rotates the line back home
    if (ctl.push) begin
      line_r[0] <= push_val;
    end else if (cnt_r != '0 && !ctl.start) begin
      line_r[0] <= line_r[bie_pkg::HIGH_WINDOW-1];
    end
    for (int k = 1; k < bie_pkg::HIGH_WINDOW; k++) begin
      if (ctl.push || (cnt_r != '0 && !ctl.start)) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign busy    = cnt_r != '0;
  assign max_val = max_r;

endmodule

@@ src/bar_indicator_engine.sv @@
// Top level: bar sequencer, delay lines, running sums and result register.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid / in_stall / in_*     | in
//  result  | out_valid / out_stall / out_*  | out
//
// The time from accept to the next accept is taken up mostly by the bit-serial dividers
// that run the three means and the rate of change side by side; the result beat is
// registered in S_DONE, after the dividers and the high window have gone idle.
// A new bar is taken while the previous result still waits on out_stall.
// rst_n is synchronous; after reset the first bar opens a series.
// History past the fill count reads as zero, so no clearing pass is needed.
`timescale 1ns / 1ps
module bar_indicator_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_series,
  input  logic [31:0] in_bar_time,
  input  logic [31:0] in_high_price,
  input  logic [31:0] in_low_price,
  input  logic [31:0] in_close_price,
  input  logic [47:0] in_traded_volume,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_time,
  output logic [31:0] out_bar_index,
  output logic [47:0] out_volume_mean,
  output logic [31:0] out_close_mean,
  output logic [31:0] out_highest_high,
  output logic [31:0] out_avg_true_range,
  output logic signed [31:0] out_rate_of_change
);

  bie_pkg::state_t state_r, state_nxt;

  // captured bar
  logic [31:0]     time_r;
  bie_pkg::price_t hi_r, lo_r, cl_r;
  bie_pkg::vol_t   vol_r;

  bie_pkg::cnt_t   bars_r;
  bie_pkg::caddr_t wp_r;
  bie_pkg::price_t prev_r, old_r, trange_r;
  logic            roc_ok_r;

  bie_pkg::csum_t  csum_r;
  bie_pkg::vsum_t  vsum_r;
  bie_pkg::rsum_t  rsum_r;

  bie_pkg::vol_t   vline_r [bie_pkg::VOLUME_WINDOW];
  bie_pkg::price_t rline_r [bie_pkg::RANGE_WINDOW];

  logic            out_valid_r;
  logic [31:0]     o_time_r, o_idx_r, o_cm_r, o_hh_r, o_atr_r, o_roc_r;
  logic [47:0]     o_vm_r;

  logic            accept, load_out, out_free;
  bie_pkg::unit_ctl_t ctl;
  logic            ram_we;
  bie_pkg::caddr_t ram_raddr, prev_addr;
  bie_pkg::price_t ram_rdata;

  logic            dv_busy, dc_busy, dr_busy, dq_busy, hw_busy;
  bie_pkg::div_t   q_vm, q_cm, q_atr, q_roc;
  bie_pkg::price_t hmax;
  bie_pkg::div_t   roc_dividend;

  bie_pkg::price_t tr_a, tr_b, tr_c, tr_m, prev_eff;
  logic [bie_pkg::DIV_W:0] roc_diff;
  logic [31:0]     roc_val;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign prev_addr = (wp_r == '0) ? bie_pkg::caddr_t'(bie_pkg::CLOSE_WINDOW - 1)
                                  : wp_r - 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bie_pkg::S_IDLE:   if (in_valid) state_nxt = bie_pkg::S_RD_OLD;
      bie_pkg::S_RD_OLD: state_nxt = bie_pkg::S_TR;
      bie_pkg::S_TR:     state_nxt = bie_pkg::S_PUSH;
      bie_pkg::S_PUSH:   state_nxt = bie_pkg::S_GO;
      bie_pkg::S_GO:     state_nxt = bie_pkg::S_WAIT;
      bie_pkg::S_WAIT: begin
        if (!dq_busy && !dv_busy && !dc_busy && !dr_busy && !hw_busy) begin
          state_nxt = bie_pkg::S_DONE;
        end
      end
      bie_pkg::S_DONE:   if (out_free) state_nxt = bie_pkg::S_IDLE;
      default:           state_nxt = bie_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    ctl       = '0;
    ram_we    = 1'b0;
    ram_raddr = wp_r;
    load_out  = 1'b0;
    case (state_r)
      bie_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        ram_raddr = prev_addr;
      end
      bie_pkg::S_RD_OLD: ram_raddr = wp_r;
      bie_pkg::S_PUSH: begin
        ctl.push = 1'b1;
        ram_we   = 1'b1;
      end
      bie_pkg::S_GO:   ctl.start = 1'b1;
      bie_pkg::S_DONE: load_out  = out_free;
      default: ;
    endcase
  end

  // true range from the three spans; negative high-low never wins
  always_comb begin
    prev_eff = (bars_r == '0) ? '0 : prev_r;
    tr_a = (hi_r >= lo_r) ? hi_r - lo_r : '0;
    tr_b = (hi_r >= prev_eff) ? hi_r - prev_eff : prev_eff - hi_r;
    tr_c = (lo_r >= prev_eff) ? lo_r - prev_eff : prev_eff - lo_r;
    tr_m = tr_a;
    if (tr_b > tr_m) tr_m = tr_b;
    if (tr_c > tr_m) tr_m = tr_c;
    if (bars_r == '0) tr_m = '0;
  end

  assign roc_dividend = bie_pkg::div_t'({cl_r, 16'h0000})
                      + bie_pkg::div_t'(prev_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bie_pkg::S_IDLE;
      bars_r      <= '0;
      wp_r        <= '0;
      csum_r      <= '0;
      vsum_r      <= '0;
      rsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_start_series) begin
        bars_r <= '0;
        csum_r <= '0;
        vsum_r <= '0;
        rsum_r <= '0;
      end
      if (state_r == bie_pkg::S_PUSH) begin
        csum_r <= csum_r + bie_pkg::csum_t'(cl_r)
                - ((bars_r >= bie_pkg::cnt_t'(bie_pkg::CLOSE_WINDOW))
                   ? bie_pkg::csum_t'(old_r) : '0);
        vsum_r <= vsum_r + bie_pkg::vsum_t'(vol_r)
                - ((bars_r >= bie_pkg::cnt_t'(bie_pkg::VOLUME_WINDOW))
                   ? bie_pkg::vsum_t'(vline_r[bie_pkg::VOLUME_WINDOW-1]) : '0);
        rsum_r <= rsum_r + bie_pkg::rsum_t'(trange_r)
                - ((bars_r >= bie_pkg::cnt_t'(bie_pkg::RANGE_WINDOW))
                   ? bie_pkg::rsum_t'(rline_r[bie_pkg::RANGE_WINDOW-1]) : '0);
        if (bars_r != '1) bars_r <= bars_r + 1'b1;
        wp_r <= (wp_r == bie_pkg::caddr_t'(bie_pkg::CLOSE_WINDOW - 1)) ? '0 : wp_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (accept) begin
      time_r <= in_bar_time;
      hi_r   <= in_high_price;
      lo_r   <= in_low_price;
      cl_r   <= in_close_price;
      vol_r  <= in_traded_volume;
    end
    if (state_r == bie_pkg::S_RD_OLD) prev_r <= ram_rdata;
    if (state_r == bie_pkg::S_TR) begin
      old_r    <= ram_rdata;
      trange_r <= tr_m;
      roc_ok_r <= (bars_r != '0) && (prev_r != '0);
    end
    if (state_r == bie_pkg::S_PUSH) begin
      vline_r[0] <= vol_r;
      rline_r[0] <= trange_r;
      for (int k = 1; k < bie_pkg::VOLUME_WINDOW; k++) vline_r[k] <= vline_r[k-1];
      for (int k = 1; k < bie_pkg::RANGE_WINDOW; k++)  rline_r[k] <= rline_r[k-1];
    end
    if (load_out) begin
      o_time_r <= time_r;
      o_idx_r  <= bars_r;
      o_vm_r   <= (bars_r >= bie_pkg::cnt_t'(bie_pkg::VOLUME_WINDOW))
                  ? q_vm[bie_pkg::VOL_W-1:0] : '0;
      o_cm_r   <= (bars_r >= bie_pkg::cnt_t'(bie_pkg::CLOSE_WINDOW))
                  ? q_cm[bie_pkg::PRICE_W-1:0] : '0;
      o_hh_r   <= (bars_r >= bie_pkg::cnt_t'(bie_pkg::HIGH_WINDOW)) ? hmax : '0;
      o_atr_r  <= (bars_r >= bie_pkg::cnt_t'(bie_pkg::RANGE_WINDOW + 1))
                  ? q_atr[bie_pkg::PRICE_W-1:0] : '0;
      o_roc_r  <= roc_ok_r ? roc_val : '0;
    end
  end

  // q - 1.0, clipped at the top of the signed range
  always_comb begin
    roc_diff = {1'b0, q_roc} - (bie_pkg::DIV_W + 1)'(bie_pkg::ONE_Q16);
    if (!roc_diff[bie_pkg::DIV_W]
        && roc_diff > (bie_pkg::DIV_W + 1)'(bie_pkg::ROC_MAX)) begin
      roc_val = 32'(bie_pkg::ROC_MAX);
    end else begin
      roc_val = roc_diff[31:0];
    end
  end

  bie_ram #(
    .WIDTH (bie_pkg::PRICE_W),
    .DEPTH (bie_pkg::CLOSE_WINDOW)
  ) u_close_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (cl_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bie_hwin u_hwin (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .push_val (hi_r),
    .busy     (hw_busy),
    .max_val  (hmax)
  );

  bie_sdiv u_div_vol (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.start),
    .dividend (bie_pkg::div_t'(vsum_r) + bie_pkg::div_t'(bie_pkg::VOLUME_WINDOW / 2)),
    .divisor  (bie_pkg::price_t'(bie_pkg::VOLUME_WINDOW)),
    .busy     (dv_busy),
    .quotient (q_vm)
  );

  bie_sdiv u_div_close (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.start),
    .dividend (bie_pkg::div_t'(csum_r) + bie_pkg::div_t'(bie_pkg::CLOSE_WINDOW / 2)),
    .divisor  (bie_pkg::price_t'(bie_pkg::CLOSE_WINDOW)),
    .busy     (dc_busy),
    .quotient (q_cm)
  );

  bie_sdiv u_div_range (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.start),
    .dividend (bie_pkg::div_t'(rsum_r) + bie_pkg::div_t'(bie_pkg::RANGE_WINDOW / 2)),
    .divisor  (bie_pkg::price_t'(bie_pkg::RANGE_WINDOW)),
    .busy     (dr_busy),
    .quotient (q_atr)
  );

  bie_sdiv u_div_roc (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.start),
    .dividend (roc_dividend),
    .divisor  (prev_r),
    .busy     (dq_busy),
    .quotient (q_roc)
  );

  assign out_valid          = out_valid_r;
  assign out_time           = o_time_r;
  assign out_bar_index      = o_idx_r;
  assign out_volume_mean    = o_vm_r;
  assign out_close_mean     = o_cm_r;
  assign out_highest_high   = o_hh_r;
  assign out_avg_true_range = o_atr_r;
  assign out_rate_of_change = o_roc_r;

endmodule

@@ src/bie_chk.sv @@
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module bie_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_time,
  input logic [31:0] out_bar_index,
  input logic [47:0] out_volume_mean,
  input logic [31:0] out_highest_high,
  input logic [31:0] out_avg_true_range,
  input logic [31:0] out_rate_of_change
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_time)
      && $stable(out_bar_index))
    else $error("result beat changed while stalled");

  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bar_index != 32'd0)
    else $error("bar index zero");

  a_roc_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_of_change[31] |-> out_rate_of_change >= 32'hFFFF_0000)
    else $error("rate of change below -1.0");

  a_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bar_index < 32'd15 |->
      out_avg_true_range == 32'd0 && out_highest_high == 32'd0
      && out_volume_mean == 48'd0)
    else $error("indicator nonzero before window filled");

endmodule

bind bar_indicator_engine bie_chk u_bie_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_time           (out_time),
  .out_bar_index      (out_bar_index),
  .out_volume_mean    (out_volume_mean),
  .out_highest_high   (out_highest_high),
  .out_avg_true_range (out_avg_true_range),
  .out_rate_of_change (out_rate_of_change)
);
